/* sv/fbsc_pkg.sv */
// Package with the shared constants and types of the feedback byte stream cipher.
package fbsc_pkg;

	localparam int KEY_BYTES = 16;
	localparam int KEY_IDX_W = $clog2(KEY_BYTES);
	localparam int KEY_LEN_W = 5;
	localparam int CFG_DATA_W = 64;
	localparam int CFG_ADDR_W = 6;

	localparam logic [7:0] POS_INIT = 8'h5A;
	localparam logic [7:0] POS_STEP = 8'd37;

	localparam logic [2:0] REG_KEY_LOW = 3'd0;
	localparam logic [2:0] REG_KEY_HIGH = 3'd1;
	localparam logic [2:0] REG_KEY_LEN = 3'd2;
	localparam logic [2:0] REG_INIT_FB = 3'd3;
	localparam logic [2:0] REG_ROTATE = 3'd4;

	typedef struct packed {
		logic [8*KEY_BYTES-1:0] key;
		logic [KEY_LEN_W-1:0] key_length;
		logic [7:0] initial_feedback;
		logic [2:0] rotate_amount;
	} cfg_t;

endpackage

/* sv/fbsc_if.sv */
// Stream interfaces for the plaintext and ciphertext channels.
interface fbsc_plain_if;
	logic valid;
	logic ready;
	logic [7:0] plain_byte;
	logic last_byte;

	modport source (output valid, output plain_byte, output last_byte, input ready);
	modport sink (input valid, input plain_byte, input last_byte, output ready);
endinterface

interface fbsc_cipher_if;
	logic valid;
	logic ready;
	logic [7:0] cipher_byte;
	logic last_out;

	modport source (output valid, output cipher_byte, output last_out, input ready);
	modport sink (input valid, input cipher_byte, input last_out, output ready);
endinterface

/* sv/feedback_byte_stream_cipher.sv */
// Top level of the feedback byte stream cipher: chain state and result register.
//
// The plain channel takes one plaintext byte per item with a flag that marks
// the last byte of a message; the cipher channel gives one ciphertext byte per
// item with the same flag. Both use valid and ready.
// An accepted item is encrypted in the cycle of its acceptance and its result
// appears in the output register in the next cycle.
// A new item can be accepted in every cycle, also while the previous result is
// being taken; the throughput is one item per cycle unless the receiver stalls,
// set by the chain update (key add, XOR and rotate) that feeds the next byte.
// When the receiver stalls, the result waits in the output register and the
// plain channel drops ready until that result is taken.
// The key, key length, initial feedback and rotation must be written through
// the APB-style port only while no item is in flight; the block does not
// enforce this. Reset clears the registers to their defaults (key length one),
// empties the output register and starts a new message at key index zero.
module feedback_byte_stream_cipher
	import fbsc_pkg::*;
(
	input logic clk,
	input logic arst_n,
	fbsc_plain_if.sink plain,
	fbsc_cipher_if.source cipher,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [CFG_ADDR_W-1:0] paddr,
	input logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic pready
);

	cfg_t cfg;

	logic [7:0] chain_q;
	logic [7:0] pos_q;
	logic [KEY_IDX_W-1:0] key_pos_q;
	logic start_q;
	logic out_valid_q;
	logic [7:0] cipher_q;
	logic last_q;

	logic in_acc;
	logic [KEY_LEN_W-1:0] eff_len;
	logic [KEY_IDX_W-1:0] kidx;
	logic [KEY_LEN_W-1:0] kidx_next;
	logic [7:0] key_byte;
	logic [7:0] chain_val;
	logic [7:0] mask;
	logic [7:0] mixed;
	logic [7:0] cipher_val;

	fbsc_regs u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cfg(cfg)
	);

	function automatic logic [7:0] rotl8(input logic [7:0] v, input logic [2:0] r);
		logic [15:0] dbl;
		dbl = {v, v} << r;
		return dbl[15:8];
	endfunction

	assign plain.ready = !out_valid_q || cipher.ready;
	assign in_acc = plain.valid && plain.ready;

	always_comb begin
		if (cfg.key_length == '0) begin
			eff_len = KEY_LEN_W'(1);
		end else if (cfg.key_length > KEY_LEN_W'(KEY_BYTES)) begin
			eff_len = KEY_LEN_W'(KEY_BYTES);
		end else begin
			eff_len = cfg.key_length;
		end
		kidx = ({1'b0, key_pos_q} >= KEY_LEN_W'(eff_len)) ? '0 : key_pos_q;
		kidx_next = KEY_LEN_W'(kidx) + KEY_LEN_W'(1);
		key_byte = cfg.key[kidx*8 +: 8];
		chain_val = start_q ? cfg.initial_feedback : chain_q;
		mask = key_byte + pos_q + chain_val;
		mixed = plain.plain_byte ^ mask;
		cipher_val = rotl8(mixed, cfg.rotate_amount);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= '0;
			pos_q <= POS_INIT;
			key_pos_q <= '0;
			start_q <= 1'b1;
		end else if (in_acc) begin
			if (plain.last_byte) begin
				chain_q <= '0;
				pos_q <= POS_INIT;
				key_pos_q <= '0;
				start_q <= 1'b1;
			end else begin
				chain_q <= cipher_val;
				pos_q <= pos_q + POS_STEP;
				key_pos_q <= (kidx_next >= eff_len) ? '0 : kidx_next[KEY_IDX_W-1:0];
				start_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc) begin
			out_valid_q <= 1'b1;
		end else if (cipher.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cipher_q <= cipher_val;
			last_q <= plain.last_byte;
		end
	end

	assign cipher.valid = out_valid_q;
	assign cipher.cipher_byte = cipher_q;
	assign cipher.last_out = last_q;

	a_last_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && plain.last_byte |=> start_q && pos_q == POS_INIT && key_pos_q == '0)
		else $error("Message end did not restart the chain state.");

	a_pos_step: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && !plain.last_byte |=> pos_q == 8'($past(pos_q) + POS_STEP))
		else $error("Position term did not advance by its step.");

	a_chain_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && !plain.last_byte |=> chain_q == cipher_q && !start_q)
		else $error("Chain byte differs from the last ciphertext byte.");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !cipher.ready |-> !plain.ready)
		else $error("Item taken while the output register holds a stalled result.");

endmodule

/* sv/fbsc_regs.sv */
// Configuration register file with its APB-style access port.
module fbsc_regs
	import fbsc_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [CFG_ADDR_W-1:0] paddr,
	input logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic pready,
	output cfg_t cfg
);

	logic [63:0] key_low_q;
	logic [63:0] key_high_q;
	logic [KEY_LEN_W-1:0] key_len_q;
	logic [7:0] init_fb_q;
	logic [2:0] rotate_q;
	logic wr_en;
	logic [2:0] reg_idx;

	assign pready = 1'b1;
	assign wr_en = psel & penable & pwrite;
	assign reg_idx = paddr[CFG_ADDR_W-1:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q <= '0;
			key_high_q <= '0;
			key_len_q <= KEY_LEN_W'(1);
			init_fb_q <= '0;
			rotate_q <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_KEY_LOW: key_low_q <= pwdata;
				REG_KEY_HIGH: key_high_q <= pwdata;
				REG_KEY_LEN: key_len_q <= pwdata[KEY_LEN_W-1:0];
				REG_INIT_FB: init_fb_q <= pwdata[7:0];
				REG_ROTATE: rotate_q <= pwdata[2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_KEY_LOW: prdata = key_low_q;
			REG_KEY_HIGH: prdata = key_high_q;
			REG_KEY_LEN: prdata = {{(CFG_DATA_W-KEY_LEN_W){1'b0}}, key_len_q};
			REG_INIT_FB: prdata = {{(CFG_DATA_W-8){1'b0}}, init_fb_q};
			REG_ROTATE: prdata = {{(CFG_DATA_W-3){1'b0}}, rotate_q};
			default: prdata = '0;
		endcase
	end

	assign cfg.key = {key_high_q, key_low_q};
	assign cfg.key_length = key_len_q;
	assign cfg.initial_feedback = init_fb_q;
	assign cfg.rotate_amount = rotate_q;

endmodule
